// ===== rtl/hex_dump_formatter_unit_assert.svh =====
// Assertion macros for the hex dump formatter, clocked on clk_i, reset by rst_ni.
`ifndef HEX_DUMP_FORMATTER_UNIT_ASSERT_SVH
`define HEX_DUMP_FORMATTER_UNIT_ASSERT_SVH

// Property must hold in the same cycle.
`define HDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition implies a property in the following cycle.
`define HDF_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/hdf_pkg.sv =====
// Shared constants and character helpers for the hex dump formatter.
`default_nettype none

package hdf_pkg;

  localparam int unsigned LineBytes   = 16;
  localparam int unsigned LineIdxW    = $clog2(LineBytes);
  localparam int unsigned CharW       = 8;
  localparam logic [31:0] OffsetLimit = 32'hFFFF_FFF0;

  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChColon   = 8'h3A;
  localparam logic [CharW-1:0] ChNewline = 8'h0A;
  localparam logic [CharW-1:0] ChDot     = 8'h2E;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

  function automatic logic [CharW-1:0] shown_char(input logic [CharW-1:0] b);
    shown_char = (b >= 8'd32 && b <= 8'd126) ? b : ChDot;
  endfunction

  // "OFFLIMIT:  "
  function automatic logic [CharW-1:0] offlimit_char(input logic [3:0] idx);
    case (idx)
      4'd0:    offlimit_char = 8'h4F;
      4'd1:    offlimit_char = 8'h46;
      4'd2:    offlimit_char = 8'h46;
      4'd3:    offlimit_char = 8'h4C;
      4'd4:    offlimit_char = 8'h49;
      4'd5:    offlimit_char = 8'h4D;
      4'd6:    offlimit_char = 8'h49;
      4'd7:    offlimit_char = 8'h54;
      4'd8:    offlimit_char = ChColon;
      default: offlimit_char = ChSpace;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hdf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/hex_dump_formatter_unit.sv =====
// Hex dump formatter top level: byte stream in, dump text out one character per transaction.
//
//   channel  dir  tdata            tlast        note
//   s_axis   in   data_byte [7:0]  end_of_data  one raw byte or end marker
//   m_axis   out  out_char  [7:0]  last_char    one ASCII character
//
// One character leaves per cycle while m_axis takes it; a new item is accepted only in idle,
// after every character of the last one has been made: a byte's hex digits and spacing, a line
// header first, the text column and newline when a line closes or at end of data. The output register sets that pace.
// The line's bytes sit in a 16-entry RAM whose registered read is issued ahead of the text column.
// Reset needs no clearing pass. A stalled m_axis holds the sequencer in place.
`default_nettype none

module hex_dump_formatter_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic       s_axis_tlast_i,   // end_of_data
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic      [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic            m_axis_tlast_o    // last_char
);

  localparam int unsigned IdxW = hdf_pkg::LineIdxW;
  localparam logic [31:0] OffsetStep = 32'(hdf_pkg::LineBytes);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StHdr  = 3'd1;
  localparam logic [2:0] StHex  = 3'd2;
  localparam logic [2:0] StPad  = 3'd3;
  localparam logic [2:0] StChr  = 3'd4;
  localparam logic [2:0] StNl   = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [7:0]      byte_q, byte_d;
  logic            end_q, end_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [31:0]     offset_q, offset_d;
  logic            ovalid_q, ovalid_d;
  logic [7:0]      ochar_q, ochar_d;
  logic            olast_q, olast_d;

  logic            s_acc;
  logic            emit;
  logic            offlimit;
  logic [3:0]      nib;
  logic [5:0]      pos3;
  logic [5:0]      pad_len;
  logic [4:0]      chr_len;
  logic [1:0]      hex_final;
  logic [IdxW-1:0] raddr;
  logic [7:0]      rdata;

  assign s_axis_tready_o = (state_q == StIdle);
  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;
  assign emit            = (state_q != StIdle) && (!ovalid_q || m_axis_tready_i);
  assign offlimit        = (offset_q == hdf_pkg::OffsetLimit);
  assign nib             = offset_q[{~cnt_q[2:0], 2'b00} +: 4];
  assign pos3            = {1'b0, pos_q, 1'b0} + {2'b00, pos_q};
  assign pad_len         = 6'd52 - pos3 - {4'b0000, pos_q[3:2]};
  assign chr_len         = end_q ? {1'b0, pos_q} : 5'(hdf_pkg::LineBytes);
  assign hex_final       = (pos_q[1:0] == 2'd3) ? 2'd3 : 2'd2;

  always_comb begin
    raddr = '0;
    if (state_q == StChr) begin
      raddr = emit ? (cnt_q[IdxW-1:0] + 1'b1) : cnt_q[IdxW-1:0];
    end
  end

  hdf_ram #(
    .Width (hdf_pkg::CharW),
    .Depth (hdf_pkg::LineBytes)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s_acc & ~s_axis_tlast_i),
    .waddr_i (pos_q),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    byte_d   = byte_q;
    end_d    = end_q;
    pos_d    = pos_q;
    offset_d = offset_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    ovalid_d = (ovalid_q && !m_axis_tready_i) || emit;

    unique case (state_q)
      StIdle: begin
        if (s_acc) begin
          byte_d = s_axis_tdata_i;
          end_d  = s_axis_tlast_i;
          cnt_d  = '0;
          if (s_axis_tlast_i) begin
            state_d = (pos_q != '0) ? StPad : StNl;
          end else begin
            state_d = (pos_q == '0) ? StHdr : StHex;
          end
        end
      end
      StHdr: begin
        if (emit) begin
          olast_d = 1'b0;
          if (offlimit) begin
            ochar_d = hdf_pkg::offlimit_char(cnt_q[3:0]);
          end else if (cnt_q < 6'd8) begin
            ochar_d = hdf_pkg::hex_char(nib);
          end else if (cnt_q == 6'd8) begin
            ochar_d = hdf_pkg::ChColon;
          end else begin
            ochar_d = hdf_pkg::ChSpace;
          end
          if (cnt_q == 6'd10) begin
            state_d = StHex;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      StHex: begin
        if (emit) begin
          olast_d = 1'b0;
          case (cnt_q[1:0])
            2'd0:    ochar_d = hdf_pkg::hex_char(byte_q[7:4]);
            2'd1:    ochar_d = hdf_pkg::hex_char(byte_q[3:0]);
            default: ochar_d = hdf_pkg::ChSpace;
          endcase
          if (cnt_q[1:0] == hex_final) begin
            cnt_d = '0;
            if (pos_q == '1) begin
              state_d = StChr;
            end else begin
              olast_d = 1'b1;
              pos_d   = pos_q + 1'b1;
              state_d = StIdle;
            end
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      StPad: begin
        if (emit) begin
          olast_d = 1'b0;
          ochar_d = hdf_pkg::ChSpace;
          if (cnt_q == pad_len - 6'd1) begin
            state_d = StChr;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      StChr: begin
        if (emit) begin
          olast_d = 1'b0;
          ochar_d = hdf_pkg::shown_char(rdata);
          if (cnt_q[4:0] == chr_len - 5'd1) begin
            state_d = StNl;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      StNl: begin
        if (emit) begin
          olast_d = 1'b1;
          ochar_d = hdf_pkg::ChNewline;
          state_d = StIdle;
          pos_d   = '0;
          if (end_q) begin
            offset_d = '0;
          end else if (!offlimit) begin
            offset_d = offset_q + OffsetStep;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      end_q    <= 1'b0;
      pos_q    <= '0;
      offset_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      end_q    <= end_d;
      pos_q    <= pos_d;
      offset_q <= offset_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = ochar_q;
  assign m_axis_tlast_o  = olast_q;

`include "hex_dump_formatter_unit_assert.svh"

  `HDF_ASSERT_NEXT(a_last_to_idle, emit && olast_d, (state_q == StIdle) && m_axis_tlast_o, "last char left item open")
  `HDF_ASSERT(a_offset_aligned, offset_q[IdxW-1:0] == '0, "line offset not line aligned")
  `HDF_ASSERT(a_chr_in_range, (state_q != StChr) || (cnt_q[4:0] < chr_len), "text column index beyond line length")
  `HDF_ASSERT_NEXT(a_end_flush, s_acc && s_axis_tlast_i, (state_q == StPad) || (state_q == StNl), "end marker did not start flush")
  `HDF_ASSERT_NEXT(a_idle_holds, (state_q == StIdle) && !s_acc, $stable(pos_q) && $stable(offset_q), "line state moved while idle")

endmodule

`default_nettype wire
